>>> rtl/crtcs_pkg.sv
`default_nettype none

package crtcs_pkg;

  // Item operation codes.
  typedef logic [1:0] op_t;
  localparam op_t OP_READ  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_TICK  = 2'd2;

  typedef logic [2:0]  addr_t;
  typedef logic [7:0]  byte_t;
  typedef logic [15:0] cycles_t;

  // Bus register addresses with special meaning.
  localparam addr_t ADDR_INIT = 3'd0;
  localparam addr_t ADDR_CMD  = 3'd1;

  // Register file slots that hold interrupt and status.
  localparam int RF_INT    = 0;
  localparam int RF_STATUS = 1;

  // Status and interrupt bit positions.
  localparam int B_SPLIT2 = 0;
  localparam int B_READY  = 1;
  localparam int B_SPLIT1 = 2;
  localparam int B_LZERO  = 3;
  localparam int B_VBLANK = 4;
  localparam int B_RDFLAG = 5;

  // Mode flag bit positions.
  localparam int M_GFX  = 0;
  localparam int M_DISP = 1;
  localparam int M_CUR  = 2;
  localparam int M_NEXT = 3;

  // Command byte groups, selected by the top three bits.
  typedef logic [2:0] cmd_grp_t;
  localparam cmd_grp_t GRP_MODE = 3'b001;
  localparam cmd_grp_t GRP_ACK  = 3'b010;
  localparam cmd_grp_t GRP_IEN  = 3'b011;
  localparam cmd_grp_t GRP_IDIS = 3'b100;

  localparam byte_t CMD_RESET    = 8'h00;
  localparam logic [3:0] CMD_PTR_HI = 4'h1;

  // Commands that complete at the next vertical blank.
  localparam byte_t DCMD_A2 = 8'ha2;
  localparam byte_t DCMD_A4 = 8'ha4;
  localparam byte_t DCMD_A9 = 8'ha9;
  localparam byte_t DCMD_AA = 8'haa;
  localparam byte_t DCMD_AB = 8'hab;
  localparam byte_t DCMD_AC = 8'hac;
  localparam byte_t DCMD_AD = 8'had;
  localparam byte_t DCMD_BB = 8'hbb;
  localparam byte_t DCMD_BD = 8'hbd;

  // Configuration register indexes and reset values.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ROW_PERIOD   = 2'd0;
  localparam cfg_idx_t CFG_LAST_ROW     = 2'd1;
  localparam cfg_idx_t CFG_STROBE_DELAY = 2'd2;

  localparam logic [15:0] ROW_PERIOD_RST   = 16'd4500;
  localparam logic [7:0]  LAST_ROW_RST     = 8'd36;
  localparam logic [15:0] STROBE_DELAY_RST = 16'd200;
  localparam logic [7:0]  ROW_COUNT_RST    = 8'd36;

  // True for command bytes that are held until vertical blank.
  function automatic logic is_delayed_cmd(input byte_t d);
    logic hit;
    case (d) inside
      DCMD_A2, DCMD_A4, DCMD_A9, DCMD_AA, DCMD_AB,
      DCMD_AC, DCMD_AD, DCMD_BB, DCMD_BD: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

>>> rtl/crtcs_chan_if.sv
`default_nettype none

// Request channel: one register access or tick per transaction.
interface crtcs_req_if;
  import crtcs_pkg::*;

  logic    valid;
  logic    ready;
  op_t     op;
  addr_t   addr;
  byte_t   wdata;
  cycles_t cycles;

  modport source (output valid, output op, output addr, output wdata, output cycles,
                  input ready);
  modport sink (input valid, input op, input addr, input wdata, input cycles,
                output ready);
endinterface

// Response channel: one result per request transaction.
interface crtcs_rsp_if;
  import crtcs_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rdata;
  byte_t int_status;
  byte_t status;
  byte_t mask_changed;
  logic  row_strobe;
  logic  frame_start;
  logic  graphics_on;
  logic  display_on;
  logic  cursor_on;
  logic  next_field_sel;

  modport source (output valid, output rdata, output int_status, output status,
                  output mask_changed, output row_strobe, output frame_start,
                  output graphics_on, output display_on, output cursor_on,
                  output next_field_sel, input ready);
  modport sink (input valid, input rdata, input int_status, input status,
                input mask_changed, input row_strobe, input frame_start,
                input graphics_on, input display_on, input cursor_on,
                input next_field_sel, output ready);
endinterface

`default_nettype wire

>>> rtl/crt_controller_command_status.sv
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one transaction per cycle while not stalled; all state updates in a
// single pass of logic between the request handshake and the response register.
// A new request is taken whenever the response register is empty or being drained.
// Synchronous reset restores all state registers, timers and configuration defaults
// and leaves the response channel empty.
`default_nettype none

module crt_controller_command_status #(
  parameter int INIT_REG_COUNT = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  crtcs_req_if.sink        req,
  crtcs_rsp_if.source      rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import crtcs_pkg::*;

  localparam int PTR_W = $clog2(INIT_REG_COUNT);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(INIT_REG_COUNT - 1);

  // Configuration registers.
  logic [15:0] row_period;
  logic [7:0]  last_row;
  logic [15:0] row_strobe_delay;

  // Block state.
  byte_t             init_regs [INIT_REG_COUNT];
  logic [PTR_W-1:0]  init_pointer;
  byte_t             reg_file [8];
  byte_t             int_mask;
  logic              command_pending;
  logic signed [31:0] row_timer;
  logic [7:0]        row_count;
  logic signed [17:0] strobe_timer;
  logic [3:0]        mode_flags;

  // Next-state values.
  byte_t             init_regs_next [INIT_REG_COUNT];
  logic [PTR_W-1:0]  init_pointer_next;
  byte_t             reg_file_next [8];
  byte_t             int_mask_next;
  logic              command_pending_next;
  logic signed [31:0] row_timer_next;
  logic [7:0]        row_count_next;
  logic signed [17:0] strobe_timer_next;
  logic [3:0]        mode_flags_next;

  // Per-item results and tick helpers.
  byte_t              rdata_next;
  logic               strobe_next;
  logic               frame_next;
  logic signed [32:0] timer_diff;
  logic signed [31:0] timer_sat;
  logic [8:0]         row_inc;
  logic               accept;
  logic               cfg_write;

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;

  // APB configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      CFG_ROW_PERIOD:   prdata = {16'd0, row_period};
      CFG_LAST_ROW:     prdata = {24'd0, last_row};
      CFG_STROBE_DELAY: prdata = {16'd0, row_strobe_delay};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_period       <= ROW_PERIOD_RST;
      last_row         <= LAST_ROW_RST;
      row_strobe_delay <= STROBE_DELAY_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        CFG_ROW_PERIOD:   row_period       <= pwdata[15:0];
        CFG_LAST_ROW:     last_row         <= pwdata[7:0];
        CFG_STROBE_DELAY: row_strobe_delay <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Row timer step with saturation at the signed minimum.
  assign timer_diff = $signed({row_timer[31], row_timer}) - $signed({17'd0, req.cycles});
  assign timer_sat  = (timer_diff[32] && !timer_diff[31]) ? {1'b1, 31'd0} : timer_diff[31:0];
  assign row_inc    = {1'b0, row_count} + 9'd1;

  // Single-pass item processing.
  always_comb begin
    init_regs_next       = init_regs;
    init_pointer_next    = init_pointer;
    reg_file_next        = reg_file;
    int_mask_next        = int_mask;
    command_pending_next = command_pending;
    row_timer_next       = row_timer;
    row_count_next       = row_count;
    strobe_timer_next    = strobe_timer;
    mode_flags_next      = mode_flags;
    rdata_next           = 8'd0;
    strobe_next          = 1'b0;
    frame_next           = 1'b0;

    case (req.op)
      OP_READ: begin
        rdata_next = reg_file[req.addr];
      end
      OP_WRITE: begin
        if (req.addr == ADDR_INIT) begin
          // Init register data write; the pointer stops at the last entry.
          init_regs_next[init_pointer] = req.wdata;
          init_pointer_next = (init_pointer >= PTR_MAX) ? PTR_MAX : init_pointer + 1'b1;
        end else if (req.addr == ADDR_CMD) begin
          if (req.wdata == CMD_RESET) begin
            for (int i = 0; i < INIT_REG_COUNT; i++) begin
              init_regs_next[i] = 8'd0;
            end
            init_pointer_next        = '0;
            reg_file_next[RF_INT]    = 8'd0;
            reg_file_next[RF_STATUS] = 8'd0;
            reg_file_next[RF_STATUS][B_RDFLAG] = 1'b1;
            command_pending_next     = 1'b0;
            row_timer_next           = '0;
            mode_flags_next[M_GFX]   = 1'b0;
            mode_flags_next[M_DISP]  = 1'b0;
          end else if (is_delayed_cmd(req.wdata)) begin
            command_pending_next = 1'b1;
            reg_file_next[RF_STATUS][B_RDFLAG] = 1'b0;
          end else if (req.wdata[7:4] == CMD_PTR_HI) begin
            // Pointer load, clamped to the last init register.
            init_pointer_next = (PTR_W'(req.wdata[3:0]) > PTR_MAX) ? PTR_MAX
                                                                   : PTR_W'(req.wdata[3:0]);
          end else begin
            case (req.wdata[7:5])
              GRP_MODE: begin
                if (req.wdata[1]) mode_flags_next[M_GFX] = req.wdata[0];
                if (req.wdata[4]) mode_flags_next[M_CUR] = req.wdata[0];
                if (req.wdata[3]) begin
                  mode_flags_next[M_DISP] = req.wdata[0];
                  mode_flags_next[M_NEXT] = req.wdata[2];
                end
              end
              GRP_ACK: begin
                reg_file_next[RF_INT]    = reg_file[RF_INT] & ~{3'd0, req.wdata[4:0]};
                reg_file_next[RF_STATUS] = reg_file[RF_STATUS] & ~{3'd0, req.wdata[4:0]};
              end
              GRP_IEN:  int_mask_next = int_mask | {3'd0, req.wdata[4:0]};
              GRP_IDIS: int_mask_next = int_mask & ~{3'd0, req.wdata[4:0]};
              default: ;
            endcase
          end
        end else begin
          reg_file_next[req.addr] = req.wdata;
        end
      end
      OP_TICK: begin
        row_timer_next = timer_sat;
        // Row event: only with the vertical blank interrupt enabled.
        if (timer_sat <= 32'sd0 && int_mask[B_VBLANK]) begin
          row_timer_next = timer_sat + $signed({16'd0, row_period});
          reg_file_next[RF_STATUS][B_LZERO] = 1'b1;
          if (row_inc == {1'b0, init_regs[12]}) begin
            reg_file_next[RF_STATUS][B_SPLIT1] = 1'b1;
            if (int_mask[B_SPLIT1]) reg_file_next[RF_INT][B_SPLIT1] = 1'b1;
          end else if (row_inc == {1'b0, init_regs[13]}) begin
            reg_file_next[RF_STATUS][B_SPLIT2] = 1'b1;
            if (int_mask[B_SPLIT2]) reg_file_next[RF_INT][B_SPLIT2] = 1'b1;
          end
          strobe_timer_next = $signed({2'd0, row_strobe_delay});
          if (row_inc > {1'b0, last_row}) begin
            // Vertical blank starts; a pending command completes here.
            frame_next = 1'b1;
            reg_file_next[RF_STATUS][B_VBLANK] = 1'b1;
            reg_file_next[RF_INT][B_VBLANK]    = 1'b1;
            if (command_pending) begin
              command_pending_next = 1'b0;
              reg_file_next[RF_STATUS][B_RDFLAG] = 1'b1;
              reg_file_next[RF_STATUS][B_READY]  = 1'b1;
              reg_file_next[RF_INT][B_READY]     = 1'b1;
            end
            row_count_next = 8'd0;
          end else begin
            row_count_next = row_inc[7:0];
          end
        end
        // Strobe countdown.
        if (strobe_timer_next > 18'sd0) begin
          strobe_timer_next = strobe_timer_next - $signed({2'd0, req.cycles});
          if (strobe_timer_next <= 18'sd0) strobe_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State registers, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < INIT_REG_COUNT; i++) begin
        init_regs[i] <= 8'd0;
      end
      for (int i = 0; i < 8; i++) begin
        reg_file[i] <= 8'd0;
      end
      reg_file[RF_STATUS][B_RDFLAG] <= 1'b1;
      init_pointer    <= '0;
      int_mask        <= 8'd0;
      command_pending <= 1'b0;
      row_timer       <= '0;
      row_count       <= ROW_COUNT_RST;
      strobe_timer    <= '0;
      mode_flags      <= 4'd0;
    end else if (accept) begin
      init_regs       <= init_regs_next;
      reg_file        <= reg_file_next;
      init_pointer    <= init_pointer_next;
      int_mask        <= int_mask_next;
      command_pending <= command_pending_next;
      row_timer       <= row_timer_next;
      row_count       <= row_count_next;
      strobe_timer    <= strobe_timer_next;
      mode_flags      <= mode_flags_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.rdata          <= rdata_next;
      rsp.int_status     <= reg_file_next[RF_INT];
      rsp.status         <= reg_file_next[RF_STATUS];
      rsp.mask_changed   <= int_mask ^ int_mask_next;
      rsp.row_strobe     <= strobe_next;
      rsp.frame_start    <= frame_next;
      rsp.graphics_on    <= mode_flags_next[M_GFX];
      rsp.display_on     <= mode_flags_next[M_DISP];
      rsp.cursor_on      <= mode_flags_next[M_CUR];
      rsp.next_field_sel <= mode_flags_next[M_NEXT];
    end
  end

  // The init pointer never runs past the last init register.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    init_pointer <= PTR_MAX)
    else $error("init pointer out of range");

  // A held result always matches the live interrupt and status registers.
  a_rsp_matches_state: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.int_status == reg_file[RF_INT] &&
                   rsp.status == reg_file[RF_STATUS]))
    else $error("response status differs from register state");

  // A frame start leaves the row counter wrapped to zero.
  a_frame_wraps: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.frame_start) |-> (row_count == 8'd0))
    else $error("frame start without row counter wrap");

  // A row strobe means the strobe timer has run out.
  a_strobe_expired: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.row_strobe) |-> (strobe_timer <= 18'sd0))
    else $error("row strobe with strobe timer still running");

  // The reset command leaves status holding only the B_RDFLAG bit.
  a_soft_reset: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_WRITE && req.addr == ADDR_CMD && req.wdata == CMD_RESET)
      |=> (reg_file[RF_STATUS] == 8'h20 && init_pointer == '0 && !command_pending))
    else $error("reset command did not clear state");

endmodule

`default_nettype wire

>>> sim/crt_controller_command_status_tb.sv
`default_nettype none

module crt_controller_command_status_tb;
  import crtcs_pkg::*;

  localparam int INIT_REGS = 15;
  localparam int INIT_LAST = INIT_REGS - 1;
  localparam logic [3:0] SPLIT1_PTR = 4'd12;
  localparam logic [3:0] SPLIT2_PTR = 4'd13;
  localparam byte_t IRQ_BITS = 8'h1f;
  localparam longint TIMER_FLOOR = 64'shFFFF_FFFF_8000_0000;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 40;
  localparam int DRAIN_TICKS = 20;
  localparam int PHASE_ITEMS = 55;
  localparam op_t OP_SPARE = 2'd3;
  localparam cmd_grp_t GRP_SPARE5 = 3'b101;
  localparam cmd_grp_t GRP_SPARE6 = 3'b110;
  localparam cmd_grp_t GRP_SPARE7 = 3'b111;
  localparam byte_t HELD_CMDS [9] = '{DCMD_A2, DCMD_A4, DCMD_A9, DCMD_AA, DCMD_AB,
                                      DCMD_AC, DCMD_AD, DCMD_BB, DCMD_BD};

  typedef struct packed {
    byte_t rdata;
    byte_t int_status;
    byte_t status;
    byte_t mask_changed;
    logic  row_strobe;
    logic  frame_start;
    logic  graphics_on;
    logic  display_on;
    logic  cursor_on;
    logic  next_field_sel;
  } crtc_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crtcs_req_if req_if ();
  crtcs_rsp_if rsp_if ();

  crt_controller_command_status u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the controller state used to predict every result.
  byte_t       init_file [INIT_REGS];
  int          init_ptr;
  byte_t       bus_regs [8];
  byte_t       irq_mask;
  logic        held_cmd;
  int          row_tmr;
  int          row_cnt;
  int          strobe_tmr;
  logic [3:0]  mode_bits;
  int          period_cfg;
  int          last_cfg;
  int          delay_cfg;

  crtc_result_t expected_results [$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           stall_left = 0;
  logic         calm = 1'b0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // The reset command clears the init file, interrupts and the row timer.
  function automatic void clear_soft();
    init_ptr = 0;
    foreach (init_file[i]) init_file[i] = '0;
    bus_regs[RF_INT] = '0;
    bus_regs[RF_STATUS] = '0;
    bus_regs[RF_STATUS][B_RDFLAG] = 1'b1;
    held_cmd = 1'b0;
    row_tmr = 0;
    mode_bits[M_GFX] = 1'b0;
    mode_bits[M_DISP] = 1'b0;
  endfunction

  // Applies one request transaction to the shadow state and returns its result.
  function automatic crtc_result_t predict_result(input op_t op, input addr_t a,
                                                  input byte_t d, input cycles_t c);
    crtc_result_t r;
    byte_t        old_mask;
    longint       t;
    int           nxt;
    r = '0;
    old_mask = irq_mask;
    case (op)
      OP_READ: r.rdata = bus_regs[a];
      OP_WRITE: begin
        if (a == ADDR_INIT) begin
          init_file[init_ptr] = d;
          if (init_ptr < INIT_LAST) init_ptr++;
        end else if (a == ADDR_CMD) begin
          if (d == CMD_RESET) begin
            clear_soft();
          end else begin
            case (d)
              DCMD_A2, DCMD_A4, DCMD_A9, DCMD_AA, DCMD_AB,
              DCMD_AC, DCMD_AD, DCMD_BB, DCMD_BD: begin
                held_cmd = 1'b1;
                bus_regs[RF_STATUS][B_RDFLAG] = 1'b0;
              end
              default: begin
                if (d[7:4] == CMD_PTR_HI) begin
                  init_ptr = (int'(d[3:0]) > INIT_LAST) ? INIT_LAST : int'(d[3:0]);
                end else begin
                  case (d[7:5])
                    GRP_MODE: begin
                      if (d[1]) mode_bits[M_GFX] = d[0];
                      if (d[4]) mode_bits[M_CUR] = d[0];
                      if (d[3]) begin
                        mode_bits[M_DISP] = d[0];
                        mode_bits[M_NEXT] = d[2];
                      end
                    end
                    GRP_ACK: begin
                      bus_regs[RF_INT] = bus_regs[RF_INT] & ~(d & IRQ_BITS);
                      bus_regs[RF_STATUS] = bus_regs[RF_STATUS] & ~(d & IRQ_BITS);
                    end
                    GRP_IEN: irq_mask = irq_mask | (d & IRQ_BITS);
                    GRP_IDIS: irq_mask = irq_mask & ~(d & IRQ_BITS);
                    default: ;
                  endcase
                end
              end
            endcase
          end
        end else begin
          bus_regs[a] = d;
        end
        r.mask_changed = old_mask ^ irq_mask;
      end
      OP_TICK: begin
        t = longint'(row_tmr) - longint'(c);
        if (t < TIMER_FLOOR) t = TIMER_FLOOR;
        row_tmr = int'(t);
        // At most one row event per tick, and only with the vblank interrupt enabled.
        if (row_tmr <= 0 && irq_mask[B_VBLANK]) begin
          nxt = row_cnt + 1;
          row_tmr = row_tmr + period_cfg;
          bus_regs[RF_STATUS][B_LZERO] = 1'b1;
          if (nxt == int'(init_file[SPLIT1_PTR])) begin
            bus_regs[RF_STATUS][B_SPLIT1] = 1'b1;
            if (irq_mask[B_SPLIT1]) bus_regs[RF_INT][B_SPLIT1] = 1'b1;
          end else if (nxt == int'(init_file[SPLIT2_PTR])) begin
            bus_regs[RF_STATUS][B_SPLIT2] = 1'b1;
            if (irq_mask[B_SPLIT2]) bus_regs[RF_INT][B_SPLIT2] = 1'b1;
          end
          strobe_tmr = delay_cfg;
          if (nxt > last_cfg) begin
            r.frame_start = 1'b1;
            bus_regs[RF_STATUS][B_VBLANK] = 1'b1;
            bus_regs[RF_INT][B_VBLANK] = 1'b1;
            if (held_cmd) begin
              held_cmd = 1'b0;
              bus_regs[RF_STATUS][B_RDFLAG] = 1'b1;
              bus_regs[RF_STATUS][B_READY] = 1'b1;
              bus_regs[RF_INT][B_READY] = 1'b1;
            end
            nxt = 0;
          end
          row_cnt = nxt & 255;
        end
        if (strobe_tmr > 0) begin
          strobe_tmr = strobe_tmr - int'(c);
          if (strobe_tmr <= 0) r.row_strobe = 1'b1;
        end
      end
      default: ;
    endcase
    r.int_status = bus_regs[RF_INT];
    r.status = bus_regs[RF_STATUS];
    r.graphics_on = mode_bits[M_GFX];
    r.display_on = mode_bits[M_DISP];
    r.cursor_on = mode_bits[M_CUR];
    r.next_field_sel = mode_bits[M_NEXT];
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Predict on each accepted request and compare each accepted response.
  always @(posedge clk) begin : scoreboard
    crtc_result_t want;
    if (!rst) begin
      if (req_if.valid && req_if.ready)
        expected_results.push_back(predict_result(req_if.op, req_if.addr,
                                                  req_if.wdata, req_if.cycles));
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: response transaction with no expected result, expected none, actual %0h",
                     $time, rsp_if.status);
        end else begin
          want = expected_results.pop_front();
          check_field("rdata", want.rdata, rsp_if.rdata);
          check_field("int_status", want.int_status, rsp_if.int_status);
          check_field("status", want.status, rsp_if.status);
          check_field("mask_changed", want.mask_changed, rsp_if.mask_changed);
          check_field("row_strobe", want.row_strobe, rsp_if.row_strobe);
          check_field("frame_start", want.frame_start, rsp_if.frame_start);
          check_field("graphics_on", want.graphics_on, rsp_if.graphics_on);
          check_field("display_on", want.display_on, rsp_if.display_on);
          check_field("cursor_on", want.cursor_on, rsp_if.cursor_on);
          check_field("next_field_sel", want.next_field_sel, rsp_if.next_field_sel);
        end
      end
    end
  end

  // Response back-pressure comes in random bursts.
  always @(negedge clk) begin
    if (calm) begin
      rsp_if.ready = 1'b1;
    end else if (stall_left > 0) begin
      rsp_if.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      rsp_if.ready = 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      rsp_if.ready = 1'b1;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sends one request transaction, possibly after a random idle burst.
  task automatic send_item(input op_t op, input addr_t a, input byte_t d, input cycles_t c);
    if (!calm && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 8)) @(negedge clk);
    req_if.valid = 1'b1;
    req_if.op = op;
    req_if.addr = a;
    req_if.wdata = d;
    req_if.cycles = c;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    req_if.valid = 1'b0;
  endtask

  task automatic rd(input addr_t a);
    send_item(OP_READ, a, byte_t'($urandom), cycles_t'($urandom));
  endtask

  task automatic wr(input addr_t a, input byte_t d);
    send_item(OP_WRITE, a, d, cycles_t'($urandom));
  endtask

  task automatic tick(input cycles_t c);
    send_item(OP_TICK, addr_t'($urandom), byte_t'($urandom), c);
  endtask

  task automatic apb_write(input cfg_idx_t idx, input int value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      CFG_ROW_PERIOD: period_cfg = value & 16'hffff;
      CFG_LAST_ROW: last_cfg = value & 8'hff;
      CFG_STROBE_DELAY: delay_cfg = value & 16'hffff;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Timing registers change only once every outstanding result has come back.
  task automatic set_timing(input int period, input int last, input int delay);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    apb_write(CFG_ROW_PERIOD, period);
    apb_write(CFG_LAST_ROW, last);
    apb_write(CFG_STROBE_DELAY, delay);
  endtask

  task automatic load_split_rows(input byte_t s1, input byte_t s2);
    wr(ADDR_CMD, {CMD_PTR_HI, SPLIT1_PTR});
    wr(ADDR_INIT, s1);
    wr(ADDR_INIT, s2);
  endtask

  task automatic test_reset_values();
    for (int i = 0; i < 8; i++) rd(addr_t'(i));
  endtask

  // Data writes go past the end and the pointer stops at the last entry; pointer loads clamp.
  task automatic test_init_pointer();
    for (int i = 0; i < INIT_REGS + 2; i++) wr(ADDR_INIT, byte_t'(i * 17));
    wr(ADDR_CMD, {CMD_PTR_HI, 4'hf});
    wr(ADDR_INIT, 8'hff);
    wr(ADDR_CMD, {CMD_PTR_HI, 4'h0});
    wr(ADDR_INIT, 8'h00);
  endtask

  task automatic test_commands();
    wr(ADDR_CMD, {GRP_MODE, 5'b11111});
    wr(ADDR_CMD, {GRP_MODE, 5'b00010});
    wr(ADDR_CMD, {GRP_MODE, 5'b01101});
    wr(ADDR_CMD, {GRP_MODE, 5'b10000});
    wr(ADDR_CMD, {GRP_IEN, 5'b11111});
    wr(ADDR_CMD, {GRP_IDIS, 5'b01010});
    wr(ADDR_CMD, {GRP_IEN, 5'b01010});
    wr(ADDR_CMD, {GRP_ACK, 5'b11111});
    wr(ADDR_CMD, {GRP_SPARE7, 5'b11111});
    wr(ADDR_CMD, {GRP_SPARE6, 5'b00011});
    wr(ADDR_CMD, {GRP_SPARE5, 5'b00000});
    wr(ADDR_CMD, 8'h05);
    send_item(OP_SPARE, 3'd7, 8'hff, 16'hffff);
    for (int i = 2; i < 8; i++) wr(addr_t'(i), (i % 2) ? 8'hff : 8'h55);
    for (int i = 0; i < 8; i++) rd(addr_t'(i));
  endtask

  // Zero period fires a row event on every tick; zero delay never strobes.
  task automatic test_row_events();
    set_timing(0, 2, 0);
    load_split_rows(8'd1, 8'd2);
    wr(ADDR_CMD, {GRP_IEN, 5'b11111});
    wr(ADDR_CMD, DCMD_A4);
    for (int i = 0; i < 5; i++) tick(16'd0);
    rd(addr_t'(RF_INT));
    rd(addr_t'(RF_STATUS));
    wr(ADDR_CMD, {GRP_ACK, 5'b11111});
    set_timing(65535, 255, 65535);
    tick(16'hffff);
    tick(16'hffff);
    tick(16'd1);
  endtask

  task automatic test_soft_reset();
    wr(ADDR_CMD, {GRP_MODE, 5'b11111});
    wr(ADDR_CMD, DCMD_BD);
    wr(ADDR_CMD, CMD_RESET);
    rd(addr_t'(RF_STATUS));
    tick(16'd3);
  endtask

  // With row events masked the timer runs far below zero, then climbs back
  // one period per event once they are enabled again.
  task automatic test_timer_drain();
    calm = 1'b1;
    wr(ADDR_CMD, {GRP_IDIS, 5'b11111});
    for (int i = 0; i < DRAIN_TICKS; i++) tick(16'hffff);
    wr(ADDR_CMD, {GRP_IEN, 5'b11111});
    for (int i = 0; i < 3; i++) tick(16'd0);
    wr(ADDR_CMD, CMD_RESET);
    calm = 1'b0;
  endtask

  // One event per tick walks the row counter through 255 and back to zero.
  task automatic test_full_frame();
    set_timing(1, 255, 1);
    wr(ADDR_CMD, {GRP_IEN, 5'b10000});
    for (int i = 0; i < 262; i++) tick(cycles_t'($urandom_range(1, 3)));
  endtask

  // Mostly well-formed traffic with random content, plus some raw noise.
  task automatic run_random_phase(input int period, input int last, input int delay);
    int span;
    int r;
    set_timing(period, last, delay);
    load_split_rows(byte_t'($urandom_range(0, last_cfg + 1)),
                    byte_t'($urandom_range(0, last_cfg + 1)));
    wr(ADDR_CMD, {GRP_IEN, 5'($urandom) | 5'b10000});
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      span = (period_cfg == 0) ? 4 : period_cfg * 2;
      if (span > 65535) span = 65535;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: tick(cycles_t'($urandom_range(0, span)));
        7: tick(cycles_t'($urandom));
        8, 9, 10: rd(addr_t'($urandom));
        11: wr(ADDR_INIT, byte_t'($urandom));
        12: wr(addr_t'($urandom_range(2, 7)), byte_t'($urandom));
        13: wr(ADDR_CMD, {GRP_MODE, 5'($urandom)});
        14: wr(ADDR_CMD, {GRP_IEN, 5'($urandom) | 5'b10000});
        15: wr(ADDR_CMD, {GRP_ACK, 5'($urandom)});
        16: begin
          r = $urandom_range(0, 11);
          if (r < 9) wr(ADDR_CMD, HELD_CMDS[r]);
          else if (r == 9) wr(ADDR_CMD, {GRP_IDIS, 5'($urandom)});
          else wr(ADDR_CMD, byte_t'($urandom));
        end
        17: begin
          r = $urandom_range(0, 9);
          if (r < 6)
            load_split_rows(byte_t'($urandom_range(0, last_cfg + 1)),
                            byte_t'($urandom_range(0, last_cfg + 1)));
          else if (r < 9) wr(ADDR_CMD, {CMD_PTR_HI, 4'($urandom)});
          else wr(ADDR_CMD, CMD_RESET);
        end
        default: send_item(op_t'($urandom_range(0, 3)), addr_t'($urandom),
                           byte_t'($urandom), cycles_t'($urandom));
      endcase
    end
  endtask

  task automatic test_random();
    run_random_phase(0, 0, 0);
    run_random_phase(1, 0, 1);
    run_random_phase(65535, 255, 65535);
    run_random_phase(40, 6, 25);
    run_random_phase($urandom_range(1, 2000), $urandom_range(0, 40), $urandom_range(1, 3000));
    calm = 1'b1;
    run_random_phase(300, 12, 100);
  endtask

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.op = OP_READ;
    req_if.addr = '0;
    req_if.wdata = '0;
    req_if.cycles = '0;
    rsp_if.ready = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // Shadow state after reset.
    period_cfg = ROW_PERIOD_RST;
    last_cfg = LAST_ROW_RST;
    delay_cfg = STROBE_DELAY_RST;
    foreach (bus_regs[i]) bus_regs[i] = '0;
    irq_mask = '0;
    row_cnt = ROW_COUNT_RST;
    strobe_tmr = 0;
    mode_bits = '0;
    clear_soft();

    repeat (2) @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_init_pointer();
    test_commands();
    test_row_events();
    test_soft_reset();
    test_timer_drain();
    test_full_frame();
    test_random();

    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/crtcs_pkg.sv
rtl/crtcs_chan_if.sv
rtl/crt_controller_command_status.sv
sim/crt_controller_command_status_tb.sv
